// ----- rtl/core/tilt_angle_kalman_filter_defines.svh -----
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TILT_ANGLE_KALMAN_FILTER_DEFINES_SVH
`define TILT_ANGLE_KALMAN_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define TAK_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tak: assertion failed");
`define TAK_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("tak: assertion failed");
`else
`define TAK_ASSERT(name, clk, rstn, prop)
`define TAK_ASSERT_NR(name, clk, prop)
`endif
`endif

// ----- rtl/core/tak_pkg.sv -----
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter package
// Shared constants, control types and the 32-bit saturation function.
// ----------------------------------------------------------------------------
`default_nettype none
package tak_pkg;

  localparam int DEF_CHANNELS       = 2;
  localparam int DEF_COEF_FRAC_BITS = 24;

  localparam logic [31:0] RST_Q_ANGLE  = 32'd16777;
  localparam logic [31:0] RST_Q_RATE   = 32'd50332;
  localparam logic [31:0] RST_R_MEAS   = 32'd8388608;
  localparam logic [31:0] RST_PERIOD   = 32'd83886;
  localparam logic [31:0] RST_GAIN     = 32'd1024000;

  localparam logic [2:0] REG_Q_ANGLE = 3'd0;
  localparam logic [2:0] REG_Q_RATE  = 3'd1;
  localparam logic [2:0] REG_R_MEAS  = 3'd2;
  localparam logic [2:0] REG_PERIOD  = 3'd3;
  localparam logic [2:0] REG_GAIN    = 3'd4;

  localparam int SAT_W = 67;

  typedef struct packed {
    logic start;
    logic sub;
    logic short_shift;
  } mac_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_W'(64'sh7FFF_FFFF)) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -SAT_W'(64'sh8000_0000)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tak_mac.sv -----
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter multiply-round-accumulate unit
// Registered stages: product, rounding shift, accumulate with saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module tak_mac import tak_pkg::*; #(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mac_ctl_t           ctl_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  input  wire logic signed [31:0] base_i,
  output logic                    done_o,
  output logic signed [31:0]      res_o
);

  localparam int RS = COEF_FRAC_BITS - 16;
  localparam logic signed [65:0] H_F = 66'sd1 <<< (COEF_FRAC_BITS - 1);

  logic signed [65:0] prod_q, rnd_q, rnd_d, rnd_f, rnd_s, neg_w;
  logic [1:0]         vld_q;
  logic signed [SAT_W-1:0] acc;

  // Rounds to nearest with ties away from zero: floor((v + h - neg) / 2^s).
  assign neg_w = prod_q[65] ? 66'sd1 : 66'sd0;
  assign rnd_f = (prod_q + H_F - neg_w) >>> COEF_FRAC_BITS;

  if (RS == 0) begin : g_noshift
    assign rnd_s = prod_q;
  end else begin : g_shift
    localparam logic signed [65:0] H_S = 66'sd1 <<< (RS - 1);
    assign rnd_s = (prod_q + H_S - neg_w) >>> RS;
  end

  assign rnd_d = ctl_i.short_shift ? rnd_s : rnd_f;
  assign acc   = ctl_i.sub ? (SAT_W'(base_i) - SAT_W'(rnd_q))
                           : (SAT_W'(base_i) + SAT_W'(rnd_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_o <= 1'b0;
    end else begin
      vld_q  <= {vld_q[0], ctl_i.start};
      done_o <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    rnd_q  <= rnd_d;
    res_o  <= sat32(acc);
  end

endmodule
`default_nettype wire

// ----- rtl/core/tak_div.sv -----
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter gain divider
// Restoring divider, one quotient bit a cycle, for (p << F) / e with e > 0.
// ----------------------------------------------------------------------------
`default_nettype none
module tak_div import tak_pkg::*; #(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic [32:0]        den_i,
  output logic                    done_o,
  output logic signed [31:0]      quo_o
);

  localparam int NW = 32 + COEF_FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dvd_q, quo_q;
  logic [32:0]   rem_q;
  logic [33:0]   rem_sh;
  logic [32:0]   den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, neg_q, fit;
  logic [31:0]   mag;

  assign mag    = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign rem_sh = {rem_q, dvd_q[NW-1]};
  assign fit    = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // The partial remainder stays below the divisor, so 33 bits hold it.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {mag, {COEF_FRAC_BITS{1'b0}}};
      rem_q <= '0;
      quo_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[31];
    end else if (busy_q) begin
      dvd_q <= {dvd_q[NW-2:0], 1'b0};
      rem_q <= fit ? 33'(rem_sh - {1'b0, den_q}) : rem_sh[32:0];
      quo_q <= {quo_q[NW-2:0], fit};
    end
  end

  // Truncated toward zero, then saturated.
  always_comb begin
    if (!neg_q && quo_q > NW'(32'h7FFF_FFFF)) begin
      quo_o = 32'sh7FFF_FFFF;
    end else if (neg_q && quo_q > NW'(32'h8000_0000)) begin
      quo_o = 32'sh8000_0000;
    end else begin
      quo_o = neg_q ? -$signed(quo_q[31:0]) : $signed(quo_q[31:0]);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tilt_angle_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter
// Per-channel angle and gyro bias Kalman filter with an APB register port.
// ----------------------------------------------------------------------------
// One item is in work at a time: 12 multiply-accumulate steps on one shared
// multiplier, plus two restoring divisions (skipped when the innovation
// variance is not positive), with sequencing states between them. The input
// stalls while an item is in work; the result sits in an output register
// until it is taken.
`default_nettype none
`include "tilt_angle_kalman_filter_defines.svh"
module tilt_angle_kalman_filter import tak_pkg::*; #(
  parameter int CHANNELS       = DEF_CHANNELS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               axis_i,
  input  wire logic signed [24:0] measured_angle_i,
  input  wire logic signed [15:0] rate_raw_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    axis_out_o,
  output logic signed [31:0]      filtered_angle_o,
  output logic signed [31:0]      corrected_rate_o
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [31:0] ONE = 32'sd1 <<< COEF_FRAC_BITS;
  localparam logic [3:0] MOP_RATE = 4'd0;
  localparam logic [3:0] MOP_P11  = 4'd5;
  localparam logic [3:0] MOP_LAST = 4'd11;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_MWAIT = 8'b0000_0100,
    S_PREP  = 8'b0000_1000,
    S_UPD   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_DWAIT = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q;

  logic [31:0] qa_q, qr_q, r_q, dt_q, gain_q;
  logic [2:0]  ridx;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qa_q   <= RST_Q_ANGLE;
      qr_q   <= RST_Q_RATE;
      r_q    <= RST_R_MEAS;
      dt_q   <= RST_PERIOD;
      gain_q <= RST_GAIN;
    end else if (cfg_wr) begin
      unique case (ridx)
        REG_Q_ANGLE: qa_q   <= pwdata;
        REG_Q_RATE:  qr_q   <= pwdata;
        REG_R_MEAS:  r_q    <= pwdata;
        REG_PERIOD:  dt_q   <= pwdata;
        REG_GAIN:    gain_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_Q_ANGLE: prdata = qa_q;
      REG_Q_RATE:  prdata = qr_q;
      REG_R_MEAS:  prdata = r_q;
      REG_PERIOD:  prdata = dt_q;
      REG_GAIN:    prdata = gain_q;
      default:     prdata = '0;
    endcase
  end

  // Per-channel filter state.
  logic signed [31:0] ang_mem_q  [CHANNELS];
  logic signed [31:0] bias_mem_q [CHANNELS];
  logic signed [31:0] c00_mem_q  [CHANNELS];
  logic signed [31:0] c01_mem_q  [CHANNELS];
  logic signed [31:0] c10_mem_q  [CHANNELS];
  logic signed [31:0] c11_mem_q  [CHANNELS];

  logic signed [31:0] rate_q, ang_q, bias_q, wc00_q, wc01_q, wc10_q, wc11_q;
  logic signed [31:0] p00_q, p01_q, p10_q, p11_q, t_q, d0_q, d1_q, d3_q;
  logic signed [31:0] err_q, k0_q, k1_q;
  logic signed [24:0] meas_q;
  logic signed [15:0] raw_q;
  logic               axis_q, ksel_q;
  logic [CW-1:0]      ch, ch_q;
  logic [3:0]         mop_q;
  logic               in_acc, out_load;
  logic signed [33:0] e;
  logic signed [31:0] corr;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign ch         = (CHANNELS > 1) ? CW'(axis_i) : '0;
  assign e          = $signed({2'b00, r_q}) + 34'(p00_q);
  assign corr       = sat32(SAT_W'(rate_q) - SAT_W'(bias_q));
  assign out_load   = (state_q == S_OUT) && (!out_valid_o || !out_stall_i);

  // Shared multiply-accumulate operand selection.
  mac_ctl_t           mac_ctl;
  logic signed [32:0] mac_a, mac_b;
  logic signed [31:0] mac_base, mac_res;
  logic               mac_sub, mac_done;

  always_comb begin
    mac_a    = 33'(k0_q);
    mac_b    = 33'(err_q);
    mac_base = bias_q;
    mac_sub  = 1'b0;
    unique case (mop_q)
      4'd0: begin
        mac_a = 33'(raw_q); mac_b = $signed({1'b0, gain_q}); mac_base = '0;
      end
      4'd1: begin mac_a = 33'(t_q);  mac_b = $signed({1'b0, dt_q}); mac_base = ang_q;  end
      4'd2: begin mac_a = 33'(d0_q); mac_b = $signed({1'b0, dt_q}); mac_base = wc00_q; end
      4'd3: begin mac_a = 33'(d1_q); mac_b = $signed({1'b0, dt_q}); mac_base = wc01_q; end
      4'd4: begin mac_a = 33'(d1_q); mac_b = $signed({1'b0, dt_q}); mac_base = wc10_q; end
      4'd5: begin mac_a = 33'(d3_q); mac_b = $signed({1'b0, dt_q}); mac_base = wc11_q; end
      4'd6: begin
        mac_a = 33'(k0_q); mac_b = 33'(p00_q); mac_base = p00_q; mac_sub = 1'b1;
      end
      4'd7: begin
        mac_a = 33'(k0_q); mac_b = 33'(p01_q); mac_base = p01_q; mac_sub = 1'b1;
      end
      4'd8: begin
        mac_a = 33'(k1_q); mac_b = 33'(p00_q); mac_base = p10_q; mac_sub = 1'b1;
      end
      4'd9: begin
        mac_a = 33'(k1_q); mac_b = 33'(p01_q); mac_base = p11_q; mac_sub = 1'b1;
      end
      4'd10: begin mac_a = 33'(k0_q); mac_b = 33'(err_q); mac_base = ang_q; end
      MOP_LAST: begin mac_a = 33'(k1_q); mac_b = 33'(err_q); mac_base = bias_q; end
      default: ;
    endcase
    mac_ctl.start       = (state_q == S_MUL);
    mac_ctl.sub         = mac_sub;
    mac_ctl.short_shift = (mop_q == MOP_RATE);
  end

  tak_mac #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .base_i (mac_base),
    .done_o (mac_done),
    .res_o  (mac_res)
  );

  logic               div_done;
  logic signed [31:0] div_res;

  tak_div #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DIV),
    .num_i   (ksel_q ? p10_q : p00_q),
    .den_i   (e[32:0]),
    .done_o  (div_done),
    .quo_o   (div_res)
  );

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mop_q   <= MOP_RATE;
      ksel_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_MUL;
            mop_q   <= MOP_RATE;
          end
        end
        S_MUL: state_q <= S_MWAIT;
        S_MWAIT: begin
          if (mac_done) begin
            mop_q <= mop_q + 1'b1;
            if (mop_q == MOP_RATE) begin
              state_q <= S_PREP;
            end else if (mop_q == MOP_P11) begin
              state_q <= S_UPD;
            end else if (mop_q == MOP_LAST) begin
              state_q <= S_OUT;
            end else begin
              state_q <= S_MUL;
            end
          end
        end
        S_PREP: state_q <= S_MUL;
        S_UPD: begin
          ksel_q  <= 1'b0;
          state_q <= (!e[33] && e != '0) ? S_DIV : S_MUL;
        end
        S_DIV: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            ksel_q  <= 1'b1;
            state_q <= ksel_q ? S_MUL : S_DIV;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      axis_q <= axis_i;
      meas_q <= measured_angle_i;
      raw_q  <= rate_raw_i;
      ch_q   <= ch;
      ang_q  <= ang_mem_q[ch];
      bias_q <= bias_mem_q[ch];
      wc00_q <= c00_mem_q[ch];
      wc01_q <= c01_mem_q[ch];
      wc10_q <= c10_mem_q[ch];
      wc11_q <= c11_mem_q[ch];
    end
    if (state_q == S_PREP) begin
      t_q  <= sat32(SAT_W'(rate_q) - SAT_W'(bias_q));
      d0_q <= sat32(SAT_W'($signed({1'b0, qa_q})) - SAT_W'(wc01_q) - SAT_W'(wc10_q));
      d1_q <= sat32(-SAT_W'(wc11_q));
      d3_q <= sat32(SAT_W'($signed({1'b0, qr_q})));
    end
    if (state_q == S_UPD) begin
      err_q <= sat32(SAT_W'(meas_q) - SAT_W'(ang_q));
      k0_q  <= '0;
      k1_q  <= '0;
    end
    if (state_q == S_DWAIT && div_done) begin
      if (ksel_q) begin
        k1_q <= div_res;
      end else begin
        k0_q <= div_res;
      end
    end
    if (state_q == S_MWAIT && mac_done) begin
      case (mop_q)
        4'd0:  rate_q <= mac_res;
        4'd1:  ang_q  <= mac_res;
        4'd2:  p00_q  <= mac_res;
        4'd3:  p01_q  <= mac_res;
        4'd4:  p10_q  <= mac_res;
        4'd5:  p11_q  <= mac_res;
        4'd6:  wc00_q <= mac_res;
        4'd7:  wc01_q <= mac_res;
        4'd8:  wc10_q <= mac_res;
        4'd9:  wc11_q <= mac_res;
        4'd10: ang_q  <= mac_res;
        default: bias_q <= mac_res;
      endcase
    end
  end

  // Channel state write-back, identity covariance after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ang_mem_q[i]  <= '0;
        bias_mem_q[i] <= '0;
        c00_mem_q[i]  <= ONE;
        c01_mem_q[i]  <= '0;
        c10_mem_q[i]  <= '0;
        c11_mem_q[i]  <= ONE;
      end
    end else if (out_load) begin
      ang_mem_q[ch_q]  <= ang_q;
      bias_mem_q[ch_q] <= bias_q;
      c00_mem_q[ch_q]  <= wc00_q;
      c01_mem_q[ch_q]  <= wc01_q;
      c10_mem_q[ch_q]  <= wc10_q;
      c11_mem_q[ch_q]  <= wc11_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      axis_out_o       <= axis_q;
      filtered_angle_o <= ang_q;
      corrected_rate_o <= corr;
    end
  end

  `TAK_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_acc |=> in_stall_o)
  `TAK_ASSERT(a_result_from_out, clk_i, rst_ni, $rose(out_valid_o) |-> $past(state_q == S_OUT))
  `TAK_ASSERT(a_mac_done_in_wait, clk_i, rst_ni, mac_done |-> state_q == S_MWAIT)
  `TAK_ASSERT_NR(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_o)

endmodule
`default_nettype wire

// ----- tb/tilt_angle_kalman_filter_test.sv -----
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter testbench
// Drives angle and gyro samples with random gaps and stalls, writes the
// noise, period and gain registers between phases, and checks each filtered
// angle and corrected rate against a fixed-point Kalman predictor.
// ----------------------------------------------------------------------------
`default_nettype none

class kalman_scoreboard;
  logic [31:0] q_angle, q_rate, r_meas, period, gain;
  logic signed [31:0] angle_est [2];
  logic signed [31:0] bias [2];
  logic signed [31:0] c00 [2], c01 [2], c10 [2], c11 [2];
  logic        want_axis [$];
  logic [31:0] want_angle [$];
  logic [31:0] want_rate [$];
  int          mismatches;

  function new();
    q_angle = tak_pkg::RST_Q_ANGLE;
    q_rate  = tak_pkg::RST_Q_RATE;
    r_meas  = tak_pkg::RST_R_MEAS;
    period  = tak_pkg::RST_PERIOD;
    gain    = tak_pkg::RST_GAIN;
    for (int c = 0; c < 2; c++) begin
      angle_est[c] = 0;
      bias[c] = 0;
      c00[c] = 32'sd16777216;
      c01[c] = 0;
      c10[c] = 0;
      c11[c] = 32'sd16777216;
    end
    mismatches = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      tak_pkg::REG_Q_ANGLE: q_angle = v;
      tak_pkg::REG_Q_RATE:  q_rate = v;
      tak_pkg::REG_R_MEAS:  r_meas = v;
      tak_pkg::REG_PERIOD:  period = v;
      tak_pkg::REG_GAIN:    gain = v;
      default: ;
    endcase
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rounds to nearest, ties away from zero.
  function longint round_shift(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function longint qmul(longint a, longint b);
    return round_shift(a * b, 24);
  endfunction

  function void note_sample(logic ax, logic signed [24:0] meas, logic signed [15:0] raw);
    longint dt, rate, d0, d1, d3, p00, p01, p10, p11, err, e, k0, k1;
    int c;
    c = ax;
    dt = longint'(period);
    rate = clamp32(round_shift(longint'(raw) * longint'(gain), 8));
    angle_est[c] = 32'(clamp32(longint'(angle_est[c]) + qmul(clamp32(rate - bias[c]), dt)));
    d0 = clamp32(longint'(q_angle) - c01[c] - c10[c]);
    d1 = clamp32(-longint'(c11[c]));
    d3 = clamp32(longint'(q_rate));
    p00 = clamp32(c00[c] + qmul(d0, dt));
    p01 = clamp32(c01[c] + qmul(d1, dt));
    p10 = clamp32(c10[c] + qmul(d1, dt));
    p11 = clamp32(c11[c] + qmul(d3, dt));
    err = clamp32(longint'(meas) - angle_est[c]);
    e = longint'(r_meas) + p00;
    if (e > 0) begin
      k0 = clamp32((p00 * (64'sd1 <<< 24)) / e);
      k1 = clamp32((p10 * (64'sd1 <<< 24)) / e);
    end else begin
      k0 = 0;
      k1 = 0;
    end
    c00[c] = 32'(clamp32(p00 - qmul(k0, p00)));
    c01[c] = 32'(clamp32(p01 - qmul(k0, p01)));
    c10[c] = 32'(clamp32(p10 - qmul(k1, p00)));
    c11[c] = 32'(clamp32(p11 - qmul(k1, p01)));
    angle_est[c] = 32'(clamp32(angle_est[c] + qmul(k0, err)));
    bias[c] = 32'(clamp32(bias[c] + qmul(k1, err)));
    want_axis.push_back(ax);
    want_angle.push_back(angle_est[c]);
    want_rate.push_back(32'(clamp32(rate - bias[c])));
  endfunction

  function void check_result(logic ax, logic [31:0] ang, logic [31:0] rt);
    logic        ea;
    logic [31:0] eang, ert;
    if (want_axis.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result axis=%0d angle=%h", ax, ang);
      return;
    end
    ea = want_axis.pop_front();
    eang = want_angle.pop_front();
    ert = want_rate.pop_front();
    if (ea !== ax || eang !== ang || ert !== rt) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp axis=%0d angle=%h rate=%h, got axis=%0d angle=%h rate=%h",
                 ea, eang, ert, ax, ang, rt);
    end
  endfunction
endclass

module tilt_angle_kalman_filter_test;
  import tak_pkg::*;

  localparam int ITEM_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 64'd2000000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               axis_i = 1'b0;
  logic signed [24:0] measured_angle_i = '0;
  logic signed [15:0] rate_raw_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               axis_out_o;
  logic signed [31:0] filtered_angle_o, corrected_rate_o;

  kalman_scoreboard filter_sb = new();
  longint cycle_count = 0;
  bit     calm = 1'b0;    // no idling in the last part of the run
  bit     hold_off = 1'b0;

  tilt_angle_kalman_filter dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stall bursts, checked at each accepted transfer.
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        filter_sb.check_result(axis_out_o, filtered_angle_o, corrected_rate_o);
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (n > 0) begin
        n--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(0, 11);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    filter_sb.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  // Valid stays high after a transfer until the next gap or drain.
  task automatic send_sample(logic ax, logic signed [24:0] meas, logic signed [15:0] raw);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    axis_i <= ax;
    measured_angle_i <= meas;
    rate_raw_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
    filter_sb.note_sample(ax, meas, raw);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (filter_sb.want_axis.size() != 0) @(posedge clk_i);
    repeat (ITEM_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic signed [24:0] meas;
    case ($urandom_range(0, 3))
      0: meas = 25'($urandom_range(0, 2 * 11796480) - 11796480);
      1: meas = 25'($urandom_range(0, 2 * 655360) - 655360);
      2: meas = $urandom_range(0, 1) ? 25'sd11796480 : -25'sd11796480;
      default: meas = $urandom_range(0, 1) ? 25'sd1 << 23 : -(25'sd1 << 23);
    endcase
    send_sample(1'($urandom_range(0, 1)), meas,
                $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 400) - 200));
  endtask

  initial begin
    logic [31:0] v;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes on both channels with reset coefficients.
    send_sample(1'b0, 25'sd11796480, 16'sh7fff);
    send_sample(1'b1, -25'sd11796480, -16'sh8000);
    send_sample(1'b0, -25'sd11796480, -16'sh8000);
    send_sample(1'b1, 25'sd11796480, 16'sh7fff);
    send_sample(1'b0, 25'sd0, 16'sd0);
    send_sample(1'b1, -25'sd1, -16'sd1);
    send_sample(1'b0, 25'sh0AAAAAA, 16'sh5555);
    send_sample(1'b1, 25'sh1555555, 16'shAAAA);
    drain();

    // Saturation corner: huge gain, period and noises drive every clamp; the
    // minimal noise makes the variance denominator shrink and can go nonpositive.
    write_reg(REG_Q_ANGLE, 32'hFFFF_FFFF);
    write_reg(REG_Q_RATE, 32'hFFFF_FFFF);
    write_reg(REG_R_MEAS, 32'd1);
    write_reg(REG_PERIOD, 32'hFFFF_FFFF);
    write_reg(REG_GAIN, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) send_random();
    drain();

    // Zero process noise, zero period, zero gain.
    write_reg(REG_Q_ANGLE, 32'd0);
    write_reg(REG_Q_RATE, 32'd0);
    write_reg(REG_R_MEAS, 32'hFFFF_FFFF);
    write_reg(REG_PERIOD, 32'd0);
    write_reg(REG_GAIN, 32'd0);
    for (int i = 0; i < 6; i++) send_random();
    // Sender pauses until everything has come back.
    drain();

    // Receiver holds off long while the sender keeps offering.
    write_reg(REG_Q_ANGLE, 32'd16777);
    write_reg(REG_Q_RATE, 32'd50332);
    write_reg(REG_R_MEAS, 32'd8388608);
    write_reg(REG_PERIOD, 32'd83886);
    write_reg(REG_GAIN, 32'd1024000);
    hold_off = 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_random();
    join
    drain();

    // Random phases with varied coefficients.
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < 5; r++) begin
        v = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 32'h0200_0000);
        if (r == 2 && v == 0) v = 1;
        write_reg(3'(r), v);
      end
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 70; i++) send_random();
      drain();
    end

    if (filter_sb.mismatches == 0 && filter_sb.want_axis.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/tak_pkg.sv
rtl/core/tak_mac.sv
rtl/core/tak_div.sv
rtl/core/tilt_angle_kalman_filter.sv
tb/tilt_angle_kalman_filter_test.sv
